[rtl/yaw_pitch_camera_pose_update_assert.svh]
// Assertion macros shared by the camera pose RTL.
// Used inside modules that have clk and rst in scope.
`ifndef YAW_PITCH_CAMERA_POSE_UPDATE_ASSERT_SVH
`define YAW_PITCH_CAMERA_POSE_UPDATE_ASSERT_SVH
// Check that an expression holds on every clock edge out of reset.
`define YPCP_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("ypcp check failed");
// Check that a condition in one cycle implies another in the next.
`define YPCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ypcp check failed");
`endif

[rtl/ypcp_pkg.sv]
// Types, constants and the arctangent table of the camera pose block.
// No dependencies.
`default_nettype none
package ypcp_pkg;
  localparam int ANGLE_FRAC   = 7;
  localparam int VEC_FRAC     = 14;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W     = 34;
  localparam int TURN_I       = 360 << ANGLE_FRAC;
  localparam int PITCH_LIM_I  = 89 << ANGLE_FRAC;

  localparam logic signed [17:0] TURN18     = 18'(TURN_I);
  localparam logic signed [16:0] HALF_TURN  = 17'(TURN_I / 2);
  localparam logic signed [16:0] TURN17     = 17'(TURN_I);
  localparam logic        [15:0] TURN16     = 16'(TURN_I);
  localparam logic signed [16:0] PITCH_LIM  = 17'(PITCH_LIM_I);
  localparam logic signed [15:0] VEC_ONE    = 16'(1 << VEC_FRAC);
  localparam logic signed [CORDIC_W-1:0] DEG90  = 34'sd1509949440;
  localparam logic signed [CORDIC_W-1:0] DEG180 = 34'sd3019898880;
  localparam logic signed [CORDIC_W-1:0] GAIN   = 34'sd652032874;

  localparam logic [2:0] REG_UP_X        = 3'd0;
  localparam logic [2:0] REG_UP_Y        = 3'd1;
  localparam logic [2:0] REG_UP_Z        = 3'd2;
  localparam logic [2:0] REG_START_X     = 3'd3;
  localparam logic [2:0] REG_START_Y     = 3'd4;
  localparam logic [2:0] REG_START_Z     = 3'd5;
  localparam logic [2:0] REG_START_YAW   = 3'd6;
  localparam logic [2:0] REG_START_PITCH = 3'd7;

  typedef enum logic [1:0] {
    CMD_ROTATE    = 2'd0,
    CMD_TRANSLATE = 2'd1,
    CMD_RESTART   = 2'd2,
    CMD_HOLD      = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_CY_GO, S_CY_WAIT, S_CP_GO, S_CP_WAIT,
    S_F0_MUL, S_F0_GET, S_F2_MUL, S_F2_GET, S_SQ_MUL, S_SQ_ACC,
    S_SQRT_GO, S_SQRT_WAIT, S_DIV_GO, S_DIV_WAIT,
    S_CRA_MUL, S_CRA_GET, S_CRB_MUL, S_CRB_GET,
    S_TR_MUL, S_TR_ACC, S_TR_POS, S_DONE
  } state_t;

  // atan(2^-i) in 2^-24 degree
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd754974720;
      5'd1:  v = 32'd445687602;
      5'd2:  v = 32'd235489088;
      5'd3:  v = 32'd119537938;
      5'd4:  v = 32'd60000934;
      5'd5:  v = 32'd30029717;
      5'd6:  v = 32'd15018523;
      5'd7:  v = 32'd7509720;
      5'd8:  v = 32'd3754917;
      5'd9:  v = 32'd1877466;
      5'd10: v = 32'd938734;
      5'd11: v = 32'd469367;
      5'd12: v = 32'd234684;
      5'd13: v = 32'd117342;
      5'd14: v = 32'd58671;
      5'd15: v = 32'd29335;
      5'd16: v = 32'd14668;
      5'd17: v = 32'd7334;
      5'd18: v = 32'd3667;
      5'd19: v = 32'd1833;
      5'd20: v = 32'd917;
      5'd21: v = 32'd458;
      5'd22: v = 32'd229;
      5'd23: v = 32'd115;
      default: v = 32'd0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

[rtl/ypcp_cordic.sv]
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
// Depends on ypcp_pkg.
`default_nettype none
module ypcp_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [16:0] angle,
  output logic                    done,
  output logic signed [31:0]      cos_out,
  output logic signed [31:0]      sin_out
);
  import ypcp_pkg::*;

  logic signed [CORDIC_W-1:0] x_q, y_q, z_q, z_in, z_fold, dx, dy, at, xo, yo;
  logic [4:0] step_q;
  logic       run_q, done_q, neg_q, neg_in;

  always_comb begin
    z_in   = {angle, 17'b0};
    neg_in = 1'b0;
    z_fold = z_in;
    if (z_in > DEG90) begin
      z_fold = z_in - DEG180;
      neg_in = 1'b1;
    end else if (z_in < -DEG90) begin
      z_fold = z_in + DEG180;
      neg_in = 1'b1;
    end
    dx = y_q >>> step_q;
    dy = x_q >>> step_q;
    at = signed'({2'b00, atan_entry(step_q)});
    xo = neg_q ? -x_q : x_q;
    yo = neg_q ? -y_q : y_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        run_q <= 1'b1;
      end else if (run_q && step_q == 5'(CORDIC_STEPS - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_q    <= GAIN;
      y_q    <= '0;
      z_q    <= z_fold;
      neg_q  <= neg_in;
      step_q <= '0;
    end else if (run_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
      step_q <= step_q + 5'd1;
    end
  end

  assign done    = done_q;
  assign cos_out = xo[31:0];
  assign sin_out = yo[31:0];
endmodule
`default_nettype wire

[rtl/ypcp_isqrt.sv]
// Digit-by-digit floor square root of a 64-bit value, one bit pair per cycle.
// Depends on ypcp_pkg.
`default_nettype none
module ypcp_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);
  import ypcp_pkg::*;

  logic [63:0] rem_q, res_q, bit_q, trial;
  logic [4:0]  cnt_q;
  logic        run_q, done_q;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        run_q <= 1'b1;
      end else if (run_q && cnt_q == 5'd31) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= radicand;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
      cnt_q <= '0;
    end else if (run_q) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
      cnt_q <= cnt_q + 5'd1;
    end
  end

  assign done = done_q;
  assign root = res_q[31:0];
endmodule
`default_nettype wire

[rtl/ypcp_div.sv]
// Restoring divider for the normalize step: 16 quotient bits, one per cycle.
// Depends on ypcp_pkg.
`default_nettype none
module ypcp_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] num,
  input  wire logic [32:0] den,
  output logic             done,
  output logic [15:0]      quo
);
  import ypcp_pkg::*;

  logic [47:0] rem_q, dsh_q;
  logic [15:0] quo_q;
  logic [3:0]  cnt_q;
  logic        run_q, done_q, ge;

  assign ge = rem_q >= dsh_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        run_q <= 1'b1;
      end else if (run_q && cnt_q == 4'd15) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= num;
      dsh_q <= {den, 15'b0};
      quo_q <= '0;
      cnt_q <= '0;
    end else if (run_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[14:0], ge};
      dsh_q <= dsh_q >> 1;
      cnt_q <= cnt_q + 4'd1;
    end
  end

  assign done = done_q;
  assign quo  = quo_q;
endmodule
`default_nettype wire

[rtl/yaw_pitch_camera_pose_update.sv]
// Fly camera pose: yaw/pitch, position, front and right unit vectors.
// Rotate and restart run two CORDIC passes, two square roots and six divides; the
// divides for the right vector are skipped when the cross product is zero. A new
// transaction is taken only in the idle state, after the last result is loaded;
// a result still waiting in the output register holds the next one in the done state.
// Synchronous active-high reset: pose (0,0,0), front +x, right +z, up +y. Uses ypcp_* files.
`default_nettype none
module yaw_pitch_camera_pose_update (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // yaw_delta, pitch_delta, move_right, move_up, move_forward
  input  wire logic [103:0] s_tdata,
  // command
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // pos_x, pos_y, pos_z, front_x/y/z, right_x/y/z, yaw_now, pitch_now, pad
  output logic [223:0]      m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import ypcp_pkg::*;

  state_t state, state_next;

  // pose and configuration
  logic [15:0]        yaw_q, start_yaw_q;
  logic signed [14:0] pitch_q, start_pitch_q;
  logic signed [31:0] pos_q [0:2];
  logic signed [31:0] start_q [0:2];
  logic signed [15:0] front_q [0:2];
  logic signed [15:0] right_q [0:2];
  logic signed [15:0] up_q [0:2];

  // transaction and work registers
  cmd_t               cmd_q;
  logic signed [15:0] yd_q, pd_q;
  logic signed [23:0] mr_q, mu_q, mf_q;
  logic signed [31:0] cy_q, sy_q, cp_q, sp_q;
  logic signed [31:0] vin_q [0:2];
  logic signed [63:0] prod_q;
  logic signed [47:0] acc_q;
  logic [63:0]        sum_q;
  logic [31:0]        len_q;
  logic [1:0]         k_q, j_q, k1, k2;
  logic               norm_right_q;
  logic               m_tvalid_q;

  logic               accept, out_load, front_in_range;
  logic signed [31:0] mul_a, mul_b, vmag_s;
  logic [31:0]        vmag;
  logic signed [17:0] yaw_sum;
  logic [15:0]        yaw_rot, yaw_start;
  logic signed [16:0] pitch_sum, yaw_signed, cord_angle, pitch_ext, sp_ext;
  logic signed [14:0] pitch_rot, pitch_start;
  logic               cord_start, cord_done, sqrt_start, sqrt_done, div_start, div_done;
  logic signed [31:0] cord_cos, cord_sin;
  logic [31:0]        sqrt_root;
  logic [15:0]        div_quo, qcap;
  logic signed [15:0] norm_val;
  logic signed [47:0] rnd;
  logic signed [48:0] pos_sum;
  logic signed [31:0] pos_sat;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = m_tvalid_q;
  assign out_load  = (state == S_DONE) && (!m_tvalid_q || m_tready);
  assign k1 = (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
  assign k2 = (k_q == 2'd0) ? 2'd2 : k_q - 2'd1;

  // angle bookkeeping: wrap yaw once, clamp pitch
  always_comb begin
    yaw_sum = signed'({2'b00, yaw_q}) + 18'(yd_q);
    if (yaw_sum < 0)            yaw_rot = 16'(yaw_sum + TURN18);
    else if (yaw_sum >= TURN18) yaw_rot = 16'(yaw_sum - TURN18);
    else                        yaw_rot = yaw_sum[15:0];
    yaw_start = (start_yaw_q >= TURN16) ? start_yaw_q - TURN16 : start_yaw_q;
    pitch_sum = 17'(pitch_q) + 17'(pd_q);
    if (pitch_sum > PITCH_LIM)       pitch_rot = PITCH_LIM[14:0];
    else if (pitch_sum < -PITCH_LIM) pitch_rot = 15'(-PITCH_LIM);
    else                             pitch_rot = pitch_sum[14:0];
    sp_ext = 17'(start_pitch_q);
    if (sp_ext > PITCH_LIM)       pitch_start = PITCH_LIM[14:0];
    else if (sp_ext < -PITCH_LIM) pitch_start = 15'(-PITCH_LIM);
    else                          pitch_start = start_pitch_q;
    yaw_signed = signed'({1'b0, yaw_q});
    if (yaw_signed > HALF_TURN) yaw_signed = yaw_signed - TURN17;
    pitch_ext  = 17'(pitch_q);
    cord_angle = (state == S_CY_GO) ? yaw_signed : pitch_ext;
  end

  // shared multiplier operand select; product is registered
  always_comb begin
    vmag   = vin_q[k_q][31] ? 32'(-vin_q[k_q]) : 32'(vin_q[k_q]);
    vmag_s = signed'(vmag);
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_F0_MUL: begin
        mul_a = cy_q;
        mul_b = cp_q;
      end
      S_F2_MUL: begin
        mul_a = sy_q;
        mul_b = cp_q;
      end
      S_SQ_MUL: begin
        mul_a = vmag_s;
        mul_b = vmag_s;
      end
      S_CRA_MUL: begin
        mul_a = 32'(front_q[k1]);
        mul_b = 32'(up_q[k2]);
      end
      S_CRB_MUL: begin
        mul_a = 32'(front_q[k2]);
        mul_b = 32'(up_q[k1]);
      end
      S_TR_MUL: begin
        case (j_q)
          2'd0: begin
            mul_a = 32'(right_q[k_q]);
            mul_b = 32'(mr_q);
          end
          2'd1: begin
            mul_a = 32'(up_q[k_q]);
            mul_b = 32'(mu_q);
          end
          default: begin
            mul_a = 32'(front_q[k_q]);
            mul_b = 32'(mf_q);
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // normalize result with cap, and translate rounding with saturation
  always_comb begin
    qcap     = (div_quo > 16'(VEC_ONE)) ? 16'(VEC_ONE) : div_quo;
    norm_val = vin_q[k_q][31] ? -signed'(qcap) : signed'(qcap);
    rnd      = (acc_q + 48'sd8192) >>> VEC_FRAC;
    pos_sum  = 49'(pos_q[k_q]) + 49'(rnd);
    if (pos_sum > 49'sd2147483647)       pos_sat = 32'sh7fffffff;
    else if (pos_sum < -49'sd2147483648) pos_sat = 32'sh80000000;
    else                                 pos_sat = pos_sum[31:0];
  end

  assign cord_start = (state == S_CY_GO) || (state == S_CP_GO);
  assign sqrt_start = (state == S_SQRT_GO);
  assign div_start  = (state == S_DIV_GO) && (len_q != '0);

  ypcp_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cord_start), .angle(cord_angle),
    .done(cord_done), .cos_out(cord_cos), .sin_out(cord_sin)
  );

  ypcp_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(sum_q),
    .done(sqrt_done), .root(sqrt_root)
  );

  ypcp_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(48'({16'b0, vmag} << 15) + 48'(len_q)), .den({len_q, 1'b0}),
    .done(div_done), .quo(div_quo)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (accept) state_next = S_DECODE;
      S_DECODE: begin
        case (cmd_q)
          CMD_ROTATE, CMD_RESTART: state_next = S_CY_GO;
          CMD_TRANSLATE:           state_next = S_TR_MUL;
          default:                 state_next = S_DONE;
        endcase
      end
      S_CY_GO:   state_next = S_CY_WAIT;
      S_CY_WAIT: if (cord_done) state_next = S_CP_GO;
      S_CP_GO:   state_next = S_CP_WAIT;
      S_CP_WAIT: if (cord_done) state_next = S_F0_MUL;
      S_F0_MUL:  state_next = S_F0_GET;
      S_F0_GET:  state_next = S_F2_MUL;
      S_F2_MUL:  state_next = S_F2_GET;
      S_F2_GET:  state_next = S_SQ_MUL;
      S_SQ_MUL:  state_next = S_SQ_ACC;
      S_SQ_ACC:  state_next = (k_q == 2'd2) ? S_SQRT_GO : S_SQ_MUL;
      S_SQRT_GO: state_next = S_SQRT_WAIT;
      S_SQRT_WAIT: if (sqrt_done) state_next = S_DIV_GO;
      S_DIV_GO: begin
        if (len_q != '0)    state_next = S_DIV_WAIT;
        else if (k_q == 2'd2) state_next = norm_right_q ? S_DONE : S_CRA_MUL;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (k_q == 2'd2) state_next = norm_right_q ? S_DONE : S_CRA_MUL;
          else             state_next = S_DIV_GO;
        end
      end
      S_CRA_MUL: state_next = S_CRA_GET;
      S_CRA_GET: state_next = S_CRB_MUL;
      S_CRB_MUL: state_next = S_CRB_GET;
      S_CRB_GET: state_next = (k_q == 2'd2) ? S_SQ_MUL : S_CRA_MUL;
      S_TR_MUL:  state_next = S_TR_ACC;
      S_TR_ACC:  state_next = (j_q == 2'd2) ? S_TR_POS : S_TR_MUL;
      S_TR_POS:  state_next = (k_q == 2'd2) ? S_DONE : S_TR_MUL;
      S_DONE:    if (out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // architectural state, configuration and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid_q    <= 1'b0;
      yaw_q         <= '0;
      pitch_q       <= '0;
      start_yaw_q   <= '0;
      start_pitch_q <= '0;
      norm_right_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i]   <= '0;
        start_q[i] <= '0;
      end
      up_q[0]    <= '0;
      up_q[1]    <= VEC_ONE;
      up_q[2]    <= '0;
      front_q[0] <= VEC_ONE;
      front_q[1] <= '0;
      front_q[2] <= '0;
      right_q[0] <= '0;
      right_q[1] <= '0;
      right_q[2] <= VEC_ONE;
    end else begin
      if (out_load)                 m_tvalid_q <= 1'b1;
      else if (m_tready)            m_tvalid_q <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_UP_X:        up_q[0]       <= cfg_data[15:0];
          REG_UP_Y:        up_q[1]       <= cfg_data[15:0];
          REG_UP_Z:        up_q[2]       <= cfg_data[15:0];
          REG_START_X:     start_q[0]    <= cfg_data;
          REG_START_Y:     start_q[1]    <= cfg_data;
          REG_START_Z:     start_q[2]    <= cfg_data;
          REG_START_YAW:   start_yaw_q   <= cfg_data[15:0];
          REG_START_PITCH: start_pitch_q <= cfg_data[14:0];
          default:         start_yaw_q   <= start_yaw_q;
        endcase
      end
      case (state)
        S_DECODE: begin
          norm_right_q <= 1'b0;
          if (cmd_q == CMD_ROTATE) begin
            yaw_q   <= yaw_rot;
            pitch_q <= pitch_rot;
          end else if (cmd_q == CMD_RESTART) begin
            yaw_q   <= yaw_start;
            pitch_q <= pitch_start;
            for (int i = 0; i < 3; i++) pos_q[i] <= start_q[i];
          end
        end
        S_DIV_GO, S_DIV_WAIT: begin
          if ((state == S_DIV_GO && len_q == '0) || (state == S_DIV_WAIT && div_done)) begin
            if (norm_right_q) right_q[k_q] <= (len_q == '0) ? '0 : norm_val;
            else              front_q[k_q] <= (len_q == '0) ? '0 : norm_val;
            if (k_q == 2'd2) norm_right_q <= 1'b1;
          end
        end
        S_TR_POS: pos_q[k_q] <= pos_sat;
        default: norm_right_q <= norm_right_q;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod_q <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_q <= cmd_t'(s_tuser);
          yd_q  <= s_tdata[15:0];
          pd_q  <= s_tdata[31:16];
          mr_q  <= s_tdata[55:32];
          mu_q  <= s_tdata[79:56];
          mf_q  <= s_tdata[103:80];
        end
      end
      S_DECODE: begin
        k_q   <= '0;
        j_q   <= '0;
        acc_q <= '0;
      end
      S_CY_WAIT: begin
        if (cord_done) begin
          cy_q <= cord_cos;
          sy_q <= cord_sin;
        end
      end
      S_CP_WAIT: begin
        if (cord_done) begin
          cp_q <= cord_cos;
          sp_q <= cord_sin;
        end
      end
      S_F0_GET: vin_q[0] <= 32'(prod_q >>> 30);
      S_F2_GET: begin
        vin_q[2] <= 32'(prod_q >>> 30);
        vin_q[1] <= sp_q;
        k_q      <= '0;
        sum_q    <= '0;
      end
      S_SQ_ACC: begin
        sum_q <= sum_q + 64'(prod_q);
        k_q   <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
      end
      S_SQRT_WAIT: if (sqrt_done) len_q <= sqrt_root;
      S_DIV_GO: begin
        if (len_q == '0) k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
      end
      S_DIV_WAIT: begin
        if (div_done) k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
      end
      S_CRA_GET: vin_q[k_q] <= prod_q[31:0];
      S_CRB_GET: begin
        vin_q[k_q] <= vin_q[k_q] - prod_q[31:0];
        k_q        <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
        sum_q      <= '0;
      end
      S_TR_ACC: begin
        acc_q <= acc_q + 48'(prod_q);
        j_q   <= j_q + 2'd1;
      end
      S_TR_POS: begin
        acc_q <= '0;
        j_q   <= '0;
        k_q   <= k_q + 2'd1;
      end
      S_DONE: begin
        if (out_load) begin
          m_tdata <= {1'b0, pitch_q, yaw_q, right_q[2], right_q[1], right_q[0],
                      front_q[2], front_q[1], front_q[0], pos_q[2], pos_q[1], pos_q[0]};
        end
      end
      default: k_q <= k_q;
    endcase
  end

  assign front_in_range = (front_q[0] <= VEC_ONE) && (front_q[0] >= -VEC_ONE) &&
                          (front_q[1] <= VEC_ONE) && (front_q[1] >= -VEC_ONE);

  `include "yaw_pitch_camera_pose_update_assert.svh"

  `YPCP_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state != S_IDLE)
  `YPCP_ASSERT_NEXT(a_out_only_done, !m_tvalid && state != S_DONE, !m_tvalid)
  `YPCP_ASSERT_ALWAYS(a_yaw_wrapped, yaw_q < TURN16)
  `YPCP_ASSERT_ALWAYS(a_front_unit, front_in_range)
endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the yaw/pitch fly camera pose unit.
// Depends on ypcp_pkg and the yaw_pitch_camera_pose_update RTL.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ypcp_pkg::*;

  localparam int IDLE_LIMIT = 20000;   // cycles with no transaction at all
  localparam int NUM_FIELDS = 11;
  localparam longint DEG = 64'sd16777216;   // one degree in the CORDIC angle unit
  localparam longint FULL_TURN = 46080;
  localparam longint PITCH_MAX = 11392;
  localparam longint UNIT = 16384;

  typedef longint vec3_t[3];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [103:0] s_tdata = '0;   // yaw_delta, pitch_delta, move_right, move_up, move_forward
  logic [1:0] s_tuser = '0;     // command
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [223:0] m_tdata;        // pos_x/y/z, front_x/y/z, right_x/y/z, yaw_now, pitch_now
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  yaw_pitch_camera_pose_update u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predicted pose state and register copies.
  longint cam_yaw, cam_pitch;
  vec3_t cam_pos, cam_front, cam_right, up_reg;
  longint start_pos[3];
  longint start_yaw_reg, start_pitch_reg;

  logic [222:0] pose_q[$];   // expected result words, oldest first
  int mismatches = 0;
  int burst_left = 0;

  const int field_w[NUM_FIELDS] = '{32, 32, 32, 16, 16, 16, 16, 16, 16, 16, 15};
  const string field_n[NUM_FIELDS] = '{"pos_x", "pos_y", "pos_z", "front_x", "front_y",
    "front_z", "right_x", "right_y", "right_z", "yaw_now", "pitch_now"};
  const longint atan_tab[16] = '{754974720, 445687602, 235489088, 119537938, 60000934,
    30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335};

  function automatic longint sx(longint v, int w);
    longint m;
    m = (64'sd1 <<< w) - 1;
    v = v & m;
    if (v[w-1]) return v - (64'sd1 <<< w);
    return v;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint wrap_turn(longint v);
    longint r;
    r = v % FULL_TURN;
    return r < 0 ? r + FULL_TURN : r;
  endfunction

  function automatic longint clamp89(longint v);
    if (v > PITCH_MAX) return PITCH_MAX;
    if (v < -PITCH_MAX) return -PITCH_MAX;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Scale a vector to unit length; rounds half up on the magnitude, caps at one.
  function automatic void unit_vec(input vec3_t v, output vec3_t o);
    longint unsigned total, len, q;
    total = 0;
    while (mag(v[0]) >= 64'sd2147483648 || mag(v[1]) >= 64'sd2147483648 ||
           mag(v[2]) >= 64'sd2147483648)
      for (int k = 0; k < 3; k++) v[k] = v[k] >>> 1;
    for (int k = 0; k < 3; k++) total += longint'(mag(v[k])) * longint'(mag(v[k]));
    len = root_floor(total);
    for (int k = 0; k < 3; k++) begin
      if (len == 0) begin
        o[k] = 0;
      end else begin
        q = ((longint'(mag(v[k])) << 15) + len) / (2 * len);
        if (q > UNIT) q = UNIT;
        o[k] = v[k] < 0 ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  // Rotation-mode CORDIC; angle in 2^-24 degree, outputs Q30.
  function automatic void trig(input longint z, output longint cs, output longint sn);
    longint x, y, dx, dy;
    bit flip;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 90 * DEG) begin
      z -= 180 * DEG;
      flip = 1;
    end else if (z < -90 * DEG) begin
      z += 180 * DEG;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic void rebuild_axes();
    longint yi, cy, sy, cp, sp;
    vec3_t f, cr;
    yi = cam_yaw;
    if (yi > FULL_TURN / 2) yi -= FULL_TURN;
    trig(yi * (64'sd1 <<< 17), cy, sy);
    trig(cam_pitch * (64'sd1 <<< 17), cp, sp);
    f[0] = (cy * cp) >>> 30;
    f[1] = sp;
    f[2] = (sy * cp) >>> 30;
    unit_vec(f, cam_front);
    cr[0] = cam_front[1] * up_reg[2] - cam_front[2] * up_reg[1];
    cr[1] = cam_front[2] * up_reg[0] - cam_front[0] * up_reg[2];
    cr[2] = cam_front[0] * up_reg[1] - cam_front[1] * up_reg[0];
    unit_vec(cr, cam_right);
  endfunction

  // Advance the predicted pose by one command and return the expected result word.
  function automatic logic [222:0] pose_step(cmd_t cmd, logic [103:0] d);
    logic [222:0] r;
    longint mv[3], acc;
    if (cmd == CMD_ROTATE) begin
      cam_yaw = wrap_turn(cam_yaw + sx(d[15:0], 16));
      cam_pitch = clamp89(cam_pitch + sx(d[31:16], 16));
      rebuild_axes();
    end else if (cmd == CMD_TRANSLATE) begin
      mv[0] = sx(d[55:32], 24);
      mv[1] = sx(d[79:56], 24);
      mv[2] = sx(d[103:80], 24);
      for (int k = 0; k < 3; k++) begin
        acc = cam_right[k] * mv[0] + up_reg[k] * mv[1] + cam_front[k] * mv[2];
        acc = (acc + 8192) >>> 14;
        cam_pos[k] = sat32(cam_pos[k] + acc);
      end
    end else if (cmd == CMD_RESTART) begin
      cam_yaw = wrap_turn(start_yaw_reg);
      cam_pitch = clamp89(start_pitch_reg);
      for (int k = 0; k < 3; k++) cam_pos[k] = sat32(start_pos[k]);
      rebuild_axes();
    end
    for (int k = 0; k < 3; k++) begin
      r[32*k +: 32] = cam_pos[k][31:0];
      r[96 + 16*k +: 16] = cam_front[k][15:0];
      r[144 + 16*k +: 16] = cam_right[k][15:0];
    end
    r[207:192] = cam_yaw[15:0];
    r[222:208] = cam_pitch[14:0];
    return r;
  endfunction

  // Send one item: bursts of back-to-back transactions with random gaps between.
  task automatic send_item(cmd_t cmd, logic [103:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(0, 7) == 0 ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = cmd;
    s_tdata = d;
    do @(posedge clk); while (!s_tready);
    pose_q.push_back(pose_step(cmd, d));
  endtask

  // Drop valid, then hold off until every expected result has come.
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    burst_left = 0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_UP_X:        up_reg[0] = sx(val, 16);
      REG_UP_Y:        up_reg[1] = sx(val, 16);
      REG_UP_Z:        up_reg[2] = sx(val, 16);
      REG_START_X:     start_pos[0] = sx(val, 32);
      REG_START_Y:     start_pos[1] = sx(val, 32);
      REG_START_Z:     start_pos[2] = sx(val, 32);
      REG_START_YAW:   start_yaw_reg = val[15:0];
      REG_START_PITCH: start_pitch_reg = sx(val, 15);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_pose_regs(logic [15:0] ux, logic [15:0] uy, logic [15:0] uz,
                               logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [15:0] yw, logic [14:0] pt);
    write_reg(REG_UP_X, {{16{ux[15]}}, ux});
    write_reg(REG_UP_Y, {{16{uy[15]}}, uy});
    write_reg(REG_UP_Z, {{16{uz[15]}}, uz});
    write_reg(REG_START_X, px);
    write_reg(REG_START_Y, py);
    write_reg(REG_START_Z, pz);
    write_reg(REG_START_YAW, {16'd0, yw});
    write_reg(REG_START_PITCH, {{17{pt[14]}}, pt});
  endtask

  function automatic logic [103:0] turn_by(logic [15:0] yd, logic [15:0] pd);
    return {72'd0, pd, yd};
  endfunction

  function automatic logic [103:0] move_by(logic [23:0] r, logic [23:0] u, logic [23:0] f);
    return {f, u, r, 32'd0};
  endfunction

  // Wrap of yaw both ways, pitch clamp at both limits, the delta extremes.
  task automatic test_rotate_limits();
    send_item(CMD_ROTATE, turn_by(16'hFFFF, 16'd0));
    send_item(CMD_ROTATE, turn_by(16'd23040, 16'd23040));
    send_item(CMD_ROTATE, turn_by(16'h7FFF, 16'h7FFF));
    send_item(CMD_ROTATE, turn_by(16'h8000, 16'h8000));
    send_item(CMD_ROTATE, turn_by(-16'sd23040, -16'sd23040));
    send_item(CMD_ROTATE, turn_by(16'd1, 16'd11392));
    send_item(CMD_HOLD, '1);
  endtask

  // Moves of extreme size, and position saturation at both ends.
  task automatic test_translate_limits();
    send_item(CMD_TRANSLATE, move_by(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    send_item(CMD_TRANSLATE, move_by(24'h800000, 24'h800000, 24'h800000));
    drain();
    set_pose_regs(16'd0, 16'd16384, 16'd0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFF00,
                  16'd0, 15'd0);
    send_item(CMD_RESTART, '0);
    send_item(CMD_TRANSLATE, move_by(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    send_item(CMD_TRANSLATE, move_by(24'h800000, 24'h800000, 24'h800000));
    send_item(CMD_TRANSLATE, move_by(24'h800000, 24'h800000, 24'h800000));
  endtask

  // Restart out of range, and a zero-length cross product giving a zero right vector.
  task automatic test_restart_cases();
    drain();
    set_pose_regs(16'd0, 16'd0, 16'd0, 32'd5, 32'hFFFFFFFB, 32'd0, 16'hFFFF, 15'h3FFF);
    send_item(CMD_RESTART, '0);
    send_item(CMD_ROTATE, turn_by(16'd100, 16'd0));
    drain();
    set_pose_regs(16'd16384, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 16'd0, 15'h4000);
    send_item(CMD_RESTART, '0);
    send_item(CMD_ROTATE, turn_by(16'd0, 16'd11392));
    send_item(CMD_TRANSLATE, move_by(24'd1000, 24'hFFF000, 24'd77));
    drain();
    set_pose_regs(16'hC000, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 16'd46079, 15'h5380);
    send_item(CMD_RESTART, '0);
    send_item(CMD_TRANSLATE, move_by(24'd12345, 24'd999, 24'hABCDEF));
  endtask

  // Mostly rotate/translate mixes with random fields; restarts and holds sprinkled.
  task automatic test_random_walk(int n);
    int pick;
    cmd_t c;
    logic [103:0] d;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      c = pick < 45 ? CMD_ROTATE : pick < 88 ? CMD_TRANSLATE :
          pick < 96 ? CMD_RESTART : CMD_HOLD;
      d = 104'({$urandom, $urandom, $urandom, $urandom});
      if (c == CMD_ROTATE && $urandom_range(0, 1)) begin
        d[15:0] = 16'($signed($urandom_range(0, 46080)) - 23040);
        d[31:16] = 16'($signed($urandom_range(0, 3000)) - 1500);
      end
      send_item(c, d);
    end
  endtask

  function automatic logic [15:0] rnd_axis();
    case ($urandom_range(0, 4))
      0: return 16'd16384;
      1: return 16'hC000;
      2: return 16'd0;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic test_random_settings();
    for (int p = 0; p < 6; p++) begin
      drain();   // pose unit idle before touching registers
      set_pose_regs(rnd_axis(), rnd_axis(), rnd_axis(), $urandom, $urandom,
                    p == 0 ? 32'h80000000 : $urandom, 16'($urandom),
                    15'($urandom));
      send_item(CMD_RESTART, '0);
      test_random_walk(145);
    end
  endtask

  // Receiver: its own stall pattern, stepping through four ready modes in turn.
  int rx_cycle = 0;
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 2000) % 4)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      2: m_tready <= (rx_cycle % 8 == 0);
      default: m_tready <= ((rx_cycle % 40) < 20) ? 1'b0 : ($urandom_range(0, 3) != 0);
    endcase
  end

  // Check each result against the oldest expectation, field by field.
  always @(posedge clk) begin
    logic [222:0] want;
    longint unsigned a, e, m;
    int off;
    if (!rst && m_tvalid && m_tready) begin
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = pose_q.pop_front();
        off = 0;
        for (int f = 0; f < NUM_FIELDS; f++) begin
          m = (64'd1 << field_w[f]) - 1;
          a = 64'(m_tdata >> off) & m;
          e = 64'(want >> off) & m;
          if (a != e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%s mismatch: expected %h, got %h", field_n[f], e, a);
          end
          off += field_w[f];
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  int quiet = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    cam_yaw = 0; cam_pitch = 0;
    cam_pos = '{0, 0, 0};
    cam_front = '{UNIT, 0, 0};
    cam_right = '{0, 0, UNIT};
    up_reg = '{0, UNIT, 0};
    start_pos = '{0, 0, 0};
    start_yaw_reg = 0; start_pitch_reg = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_rotate_limits();
    test_translate_limits();
    test_restart_cases();
    test_random_settings();
    drain();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pose_q.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
